// File: hdl/csc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column shading correction package
// Shared constants, widths and codes of the column shading correction block.
// ---------------------------------------------------------------------------
package csc_pkg;

    localparam int LAYERS      = 3;
    localparam int COLUMNS     = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int DEPTH       = LAYERS * COLUMNS;
    localparam int COL_W       = 12;
    localparam int LAYER_W     = 2;
    localparam int ADDR_W      = LAYER_W + COL_W;
    localparam int SUM_W       = 21;
    localparam int COUNT_W     = 13;
    localparam int GAIN_W      = 24;
    localparam int TARGET_W    = 16;
    localparam int DIVIDEND_W  = TARGET_W + COUNT_W + 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 24'h010000;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    localparam logic [1:0] MODE_CLEAR    = 2'd0;
    localparam logic [1:0] MODE_CALIB    = 2'd1;
    localparam logic [1:0] MODE_FINALIZE = 2'd2;
    localparam logic [1:0] MODE_CORRECT  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_COL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_END_COL   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ROW = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_END_ROW   = 3'd6;

endpackage

// File: hdl/csc_item_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column shading correction input channel
// Valid/ready channel carrying one input transaction.
// ---------------------------------------------------------------------------
interface csc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  layer;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  pixel;

    modport source (output valid, mode, layer, row, column, pixel, input ready);
    modport sink   (input valid, mode, layer, row, column, pixel, output ready);
endinterface

// File: hdl/csc_result_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column shading correction result channel
// Valid/ready channel carrying one corrected pixel transaction.
// ---------------------------------------------------------------------------
interface csc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  corrected;
    logic [1:0]  out_layer;
    logic [11:0] out_column;

    modport source (output valid, corrected, out_layer, out_column, input ready);
    modport sink   (input valid, corrected, out_layer, out_column, output ready);
endinterface

// File: hdl/column_shading_correction.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column shading correction
// Per-column flat-field calibration and gain correction for three layers,
// with statistics and gains held in two synchronous memories.
// ---------------------------------------------------------------------------
// Channel   Direction  Transaction
// item      in         mode, layer, row, column, pixel
// result    out        corrected, out_layer, out_column (correct mode only)
// cfg       in         write enable, register index, data
//
// A calibration sample is a memory read, then a write back.
// A correction runs a gain read, a multiply, then an output register load.
// Clear sweeps all 12288 entries, one per cycle; the same pass runs after reset.
// Finalize runs per layer a read, wait and write per window column, with a
// bit-serial divide and saturation where needed, then a 4096-column edge sweep.
// A stalled result holds the output register; a correction then waits to load it.
module column_shading_correction (
    input  logic                                clk,
    input  logic                                rst_n,
    csc_item_if.sink                            item,
    csc_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [csc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CAL      = 4'd2;
    localparam logic [3:0] S_CORR     = 4'd3;
    localparam logic [3:0] S_CORR_OUT = 4'd4;
    localparam logic [3:0] S_F_RD     = 4'd5;
    localparam logic [3:0] S_F_WAIT   = 4'd6;
    localparam logic [3:0] S_F_DIV    = 4'd7;
    localparam logic [3:0] S_F_SAT    = 4'd8;
    localparam logic [3:0] S_F_WR     = 4'd9;
    localparam logic [3:0] S_F_FILL   = 4'd10;

    localparam int STAT_W = csc_pkg::SUM_W + csc_pkg::COUNT_W;
    localparam int DW     = csc_pkg::DIVIDEND_W;
    localparam int SW     = csc_pkg::SUM_W;
    localparam int CW     = csc_pkg::COL_W;
    localparam int AW     = csc_pkg::ADDR_W;
    localparam int STEP_W = $clog2(DW + 1);
    localparam logic [AW-1:0]     LAST_ADDR  = AW'(csc_pkg::DEPTH - 1);
    localparam logic [CW-1:0]     LAST_COL   = CW'(csc_pkg::COLUMNS - 1);
    localparam logic [1:0]        LAST_LAYER = 2'(csc_pkg::LAYERS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DW - 1);

    logic [STAT_W-1:0]          stat_mem [csc_pkg::DEPTH];
    logic [csc_pkg::GAIN_W-1:0] gain_mem [csc_pkg::DEPTH];

    logic [15:0] target_reg [3];
    logic [11:0] first_col_reg;
    logic [12:0] end_col_reg;
    logic [11:0] first_row_reg;
    logic [12:0] end_row_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    layer_reg, layer_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0]    pixel_reg, pixel_next;
    logic          win_reg, win_next;

    logic [STAT_W-1:0]          stat_q;
    logic [csc_pkg::GAIN_W-1:0] gain_q;

    logic [DW-1:0]              quo_reg, quo_next;
    logic [SW-1:0]              rem_reg, rem_next;
    logic [SW-1:0]              div_sum_reg, div_sum_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [csc_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [csc_pkg::GAIN_W-1:0] first_gain_reg, first_gain_next;
    logic [csc_pkg::GAIN_W-1:0] last_gain_reg, last_gain_next;
    logic [31:0]                prod_reg, prod_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  corrected_reg, corrected_next;
    logic [1:0]  out_layer_reg, out_layer_next;
    logic [11:0] out_column_reg, out_column_next;

    logic [12:0]       hi_col;
    logic [12:0]       hi_row;
    logic              window_empty;
    logic              accept;
    logic [1:0]        item_layer;
    logic [AW-1:0]     rd_addr;
    logic              stat_we;
    logic [AW-1:0]     stat_waddr;
    logic [STAT_W-1:0] stat_wdata;
    logic              gain_we;
    logic [AW-1:0]     gain_waddr;
    logic [csc_pkg::GAIN_W-1:0] gain_wdata;
    logic [SW-1:0]     q_sum;
    logic [csc_pkg::COUNT_W-1:0] q_count;
    logic [SW:0]       rem_shift;
    logic              rem_ge;
    logic              out_free;

    assign hi_col = (end_col_reg < 13'(csc_pkg::COLUMNS)) ? end_col_reg
                                                           : 13'(csc_pkg::COLUMNS);
    assign hi_row = (end_row_reg < 13'(csc_pkg::MAX_ROWS)) ? end_row_reg
                                                            : 13'(csc_pkg::MAX_ROWS);
    assign window_empty = {1'b0, first_col_reg} >= hi_col;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign item_layer = (item.layer > LAST_LAYER) ? 2'd0 : item.layer;
    assign rd_addr    = (state_reg == S_IDLE) ? {item_layer, item.column}
                                              : {layer_reg, col_reg};

    assign q_sum     = stat_q[STAT_W-1:csc_pkg::COUNT_W];
    assign q_count   = stat_q[csc_pkg::COUNT_W-1:0];
    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_sum_reg};
    assign out_free  = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.corrected  = corrected_reg;
    assign result.out_layer  = out_layer_reg;
    assign result.out_column = out_column_reg;

    always_ff @(posedge clk)
    begin
        stat_q <= stat_mem[rd_addr];
        gain_q <= gain_mem[rd_addr];
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
        if (gain_we)
        begin
            gain_mem[gain_waddr] <= gain_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg[0] <= 16'd32768;
            target_reg[1] <= 16'd32768;
            target_reg[2] <= 16'd32768;
            first_col_reg <= '0;
            end_col_reg   <= 13'd4096;
            first_row_reg <= '0;
            end_row_reg   <= 13'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csc_pkg::REG_TARGET0:   target_reg[0] <= cfg_data;
                csc_pkg::REG_TARGET1:   target_reg[1] <= cfg_data;
                csc_pkg::REG_TARGET2:   target_reg[2] <= cfg_data;
                csc_pkg::REG_FIRST_COL: first_col_reg <= cfg_data[11:0];
                csc_pkg::REG_END_COL:   end_col_reg   <= cfg_data[12:0];
                csc_pkg::REG_FIRST_ROW: first_row_reg <= cfg_data[11:0];
                csc_pkg::REG_END_ROW:   end_row_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        layer_reg      <= layer_next;
        col_reg        <= col_next;
        pixel_reg      <= pixel_next;
        win_reg        <= win_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        div_sum_reg    <= div_sum_next;
        step_reg       <= step_next;
        gain_reg       <= gain_next;
        first_gain_reg <= first_gain_next;
        last_gain_reg  <= last_gain_next;
        prod_reg       <= prod_next;
        corrected_reg  <= corrected_next;
        out_layer_reg  <= out_layer_next;
        out_column_reg <= out_column_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        layer_next      = layer_reg;
        col_next        = col_reg;
        pixel_next      = pixel_reg;
        win_next        = win_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_sum_next    = div_sum_reg;
        step_next       = step_reg;
        gain_next       = gain_reg;
        first_gain_next = first_gain_reg;
        last_gain_next  = last_gain_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        corrected_next  = corrected_reg;
        out_layer_next  = out_layer_reg;
        out_column_next = out_column_reg;
        stat_we         = 1'b0;
        stat_waddr      = {layer_reg, col_reg};
        stat_wdata      = '0;
        gain_we         = 1'b0;
        gain_waddr      = {layer_reg, col_reg};
        gain_wdata      = gain_reg;

        case (state_reg)
            S_CLEAR:
            begin
                stat_we    = 1'b1;
                stat_waddr = clr_reg;
                stat_wdata = '0;
                gain_we    = 1'b1;
                gain_waddr = clr_reg;
                gain_wdata = csc_pkg::GAIN_ONE;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    layer_next = item.layer;
                    col_next   = item.column;
                    pixel_next = item.pixel;
                    win_next   = (item.layer <= LAST_LAYER)
                                 && (item.column >= first_col_reg)
                                 && ({1'b0, item.column} < hi_col)
                                 && (item.row >= first_row_reg)
                                 && ({1'b0, item.row} < hi_row);
                    case (item.mode)
                        csc_pkg::MODE_CLEAR:    state_next = S_CLEAR;
                        csc_pkg::MODE_CALIB:    state_next = S_CAL;
                        csc_pkg::MODE_FINALIZE:
                        begin
                            if (!window_empty)
                            begin
                                layer_next = 2'd0;
                                col_next   = first_col_reg;
                                state_next = S_F_RD;
                            end
                        end
                        csc_pkg::MODE_CORRECT:  state_next = S_CORR;
                        default:                state_next = S_IDLE;
                    endcase
                end
            end
            S_CAL:
            begin
                if (win_reg && (q_count != csc_pkg::COUNT_MAX))
                begin
                    stat_we    = 1'b1;
                    stat_wdata = {q_sum + SW'(pixel_reg), q_count + 1'b1};
                end
                state_next = S_IDLE;
            end
            S_CORR:
            begin
                prod_next  = 32'(pixel_reg) * 32'(gain_q);
                state_next = S_CORR_OUT;
            end
            S_CORR_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_layer_next  = layer_reg;
                    out_column_next = col_reg;
                    if (layer_reg > LAST_LAYER)
                    begin
                        corrected_next = pixel_reg;
                    end
                    else if (prod_reg[31:16] > 16'd255)
                    begin
                        corrected_next = 8'hFF;
                    end
                    else
                    begin
                        corrected_next = prod_reg[23:16];
                    end
                    state_next = S_IDLE;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_WAIT;
            end
            S_F_WAIT:
            begin
                if (q_count == '0)
                begin
                    gain_next  = csc_pkg::GAIN_ONE;
                    state_next = S_F_WR;
                end
                else if (q_sum == '0)
                begin
                    gain_next  = csc_pkg::GAIN_MAX;
                    state_next = S_F_WR;
                end
                else
                begin
                    quo_next     = {29'(target_reg[layer_reg]) * 29'(q_count), 8'd0};
                    rem_next     = '0;
                    div_sum_next = q_sum;
                    step_next    = '0;
                    state_next   = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                quo_next = {quo_reg[DW-2:0], rem_ge};
                rem_next = rem_ge ? SW'(rem_shift - {1'b0, div_sum_reg})
                                  : rem_shift[SW-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_F_SAT;
                end
            end
            S_F_SAT:
            begin
                gain_next  = (quo_reg[DW-1:csc_pkg::GAIN_W] != '0) ? csc_pkg::GAIN_MAX
                                                                  : quo_reg[23:0];
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                gain_we        = 1'b1;
                last_gain_next = gain_reg;
                if (col_reg == first_col_reg)
                begin
                    first_gain_next = gain_reg;
                end
                if (({1'b0, col_reg} + 13'd1) == hi_col)
                begin
                    col_next   = '0;
                    state_next = S_F_FILL;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_F_FILL:
            begin
                if (col_reg < first_col_reg)
                begin
                    gain_we    = 1'b1;
                    gain_wdata = first_gain_reg;
                end
                else if ({1'b0, col_reg} >= hi_col)
                begin
                    gain_we    = 1'b1;
                    gain_wdata = last_gain_reg;
                end
                if (col_reg == LAST_COL)
                begin
                    if (layer_reg == LAST_LAYER)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        layer_next = layer_reg + 1'b1;
                        col_next   = first_col_reg;
                        state_next = S_F_RD;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/csc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column shading correction checker
// Port-level assertions on the column shading correction block.
// ---------------------------------------------------------------------------
module csc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic [1:0]  item_mode,
    input logic        result_valid,
    input logic        result_ready,
    input logic [7:0]  result_corrected
);

    // The block runs its clearing pass right after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !item_ready)
        else $error("input ready right after reset");

    // A clear transaction starts the sweep, so no transaction follows directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_mode == csc_pkg::MODE_CLEAR) |=> !item_ready)
        else $error("input ready during clear sweep");

    // A correction transaction needs its gain read and multiply first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_mode == csc_pkg::MODE_CORRECT) |=> !item_ready)
        else $error("input ready during correction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_corrected)))
        else $error("stalled result changed");

endmodule

bind column_shading_correction csc_checker u_csc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_mode        (item.mode),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_corrected (result.corrected)
);
